[src/led_panel_quarter_scan_driver_core_macros.svh]
// assertion macros for the led panel quarter scan driver
// no dependencies; taken in by the files that carry assertions
`ifndef LED_PANEL_QUARTER_SCAN_DRIVER_CORE_MACROS_SVH
`define LED_PANEL_QUARTER_SCAN_DRIVER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPQSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpqsd assertion failed");

// next-cycle implication, checked outside reset
`define LPQSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpqsd assertion failed");

`endif

[src/lpqsd_pkg.sv]
// shared types and constants of the led panel quarter scan driver
// no dependencies
`timescale 1ns / 1ps

package lpqsd_pkg;

   // command codes on the request channel
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_SCAN  = 2'd2
   } cmd_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SCAN
   } state_type;

   // one result item waiting for the output side
   typedef struct packed {
      logic [7:0] shift_byte;
      logic       row_select_a;
      logic       row_select_b;
      logic       latch_last;
   } out_entry_type;

   // row address line coding, indexed by group mod 4
   localparam logic [3:0] LINE_A_CODE = 4'b0101;
   localparam logic [3:0] LINE_B_CODE = 4'b1001;

   localparam int BYTE_BITS = 8;

endpackage

[src/led_panel_quarter_scan_driver_core.sv]
// scan driver: accepts an item once the sequencer is idle; results leave through a 2-entry queue
// clear: PANEL_ROWS*PANEL_COLUMNS/8 store bytes (128 default), one store byte zeroed per cycle
// write pixel: store read, then modified byte written back
// scan: PANEL_COLUMNS/8*PANEL_ROWS/SCAN_GROUPS bytes (32 default), one per cycle on the store
// read port while the queue has room, then queued; next item taken the cycle after the last read
// reset: synchronous; starts a clearing pass of the frame store, no item taken meanwhile
// depends on lpqsd_pkg, lpqsd_ram, lpqsd_out_queue and the assertion macro header
`timescale 1ns / 1ps
`include "led_panel_quarter_scan_driver_core_macros.svh"

module led_panel_quarter_scan_driver_core #(
   parameter int PANEL_ROWS    = 16,
   parameter int PANEL_COLUMNS = 64,
   parameter int SCAN_GROUPS   = 4
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [3:0] req_pixel_row,
   input  logic [5:0] req_pixel_column,
   input  logic       req_pixel_value,
   input  logic [1:0] req_scan_group,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_shift_byte,
   output logic       rsp_row_select_a,
   output logic       rsp_row_select_b,
   output logic       rsp_latch_last
);

   import lpqsd_pkg::*;

   // frame store geometry
   localparam int COLUMN_BYTES   = PANEL_COLUMNS / 8;
   localparam int STORE_BYTES    = PANEL_ROWS * COLUMN_BYTES;
   localparam int ROWS_PER_GROUP = PANEL_ROWS / SCAN_GROUPS;
   localparam int AW = $clog2(STORE_BYTES);
   // width of the pixel index sum before it is cut to a store address
   localparam int XW = (AW > 10) ? AW : 10;
   localparam int CW = (COLUMN_BYTES > 1) ? $clog2(COLUMN_BYTES) : 1;
   localparam int RW = (ROWS_PER_GROUP > 1) ? $clog2(ROWS_PER_GROUP) : 1;

   // sequencer state
   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;

   // pending pixel write
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   logic [2:0]       wr_bit_ff, wr_bit_in;
   logic             wr_value_ff, wr_value_in;

   // scan walk: column base plus a row that steps down by the group count
   logic [AW-1:0]    col_base_ff, col_base_in;
   logic [AW-1:0]    srow_ff, srow_in;
   logic [AW-1:0]    srow_top_ff, srow_top_in;
   logic [CW-1:0]    col_cnt_ff, col_cnt_in;
   logic [RW-1:0]    row_cnt_ff, row_cnt_in;
   logic             line_a_ff, line_a_in;
   logic             line_b_ff, line_b_in;

   // tags of the store read now in flight
   logic             inflight_ff, inflight_in;
   logic             inflight_a_ff, inflight_a_in;
   logic             inflight_b_ff, inflight_b_in;
   logic             inflight_last_ff, inflight_last_in;

   // store port
   logic             ram_we;
   logic [AW-1:0]    ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic [AW-1:0]    ram_rd_addr;
   logic [7:0]       ram_rd_data;

   // queue link
   out_entry_type    push_entry;
   out_entry_type    head_entry;
   logic             q_valid;
   logic [1:0]       q_count;
   logic             rsp_pop;

   // decode
   logic             req_accept;
   logic [XW-1:0]    pix_idx_wide;
   logic [AW-1:0]    pix_idx;
   logic             pix_inside;
   logic             grp_inside;
   logic [2:0]       occupancy;
   logic             scan_issue;
   logic             scan_row_last;
   logic             scan_col_last;
   logic [7:0]       bit_mask;

   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = q_valid && !rsp_stall;

   // byte index = row + rows * (column / 8), leftmost pixel in bit 7
   assign pix_idx_wide = XW'(req_pixel_row)
                       + XW'(PANEL_ROWS) * XW'(req_pixel_column[5:3]);
   assign pix_idx      = pix_idx_wide[AW-1:0];
   assign pix_inside   = (7'(req_pixel_row) < 7'(PANEL_ROWS))
                      && (10'(req_pixel_column) < 10'(PANEL_COLUMNS));
   assign grp_inside   = (5'(req_scan_group) < 5'(SCAN_GROUPS));

   // room check: queued plus in-flight items, counting the one leaving this cycle
   assign occupancy     = 3'(q_count) + 3'(inflight_ff);
   assign scan_issue    = (state_ff == ST_SCAN) && ((occupancy - 3'(rsp_pop)) < 3'd2);
   assign scan_row_last = (row_cnt_ff == RW'(ROWS_PER_GROUP - 1));
   assign scan_col_last = (col_cnt_ff == CW'(COLUMN_BYTES - 1));

   assign bit_mask = 8'h80 >> wr_bit_ff;

   always_comb begin
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      wr_addr_in       = wr_addr_ff;
      wr_bit_in        = wr_bit_ff;
      wr_value_in      = wr_value_ff;
      col_base_in      = col_base_ff;
      srow_in          = srow_ff;
      srow_top_in      = srow_top_ff;
      col_cnt_in       = col_cnt_ff;
      row_cnt_in       = row_cnt_ff;
      line_a_in        = line_a_ff;
      line_b_in        = line_b_ff;
      inflight_in      = 1'b0;
      inflight_a_in    = line_a_ff;
      inflight_b_in    = line_b_ff;
      inflight_last_in = 1'b0;
      ram_we           = 1'b0;
      ram_wr_addr      = wr_addr_ff;
      ram_wr_data      = 8'h00;
      ram_rd_addr      = pix_idx;
      req_stall        = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            // zero one byte a cycle until the top of the store
            ram_we      = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 8'h00;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_stall = 1'b0;
            // the store read for a pixel write goes out in the accept cycle
            ram_rd_addr = pix_idx;
            if (req_valid) begin
               case (req_command)
                  CMD_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_WRITE: begin
                     if (pix_inside) begin
                        wr_addr_in  = pix_idx;
                        wr_bit_in   = req_pixel_column[2:0];
                        wr_value_in = req_pixel_value;
                        state_in    = ST_WRITE;
                     end
                  end
                  CMD_SCAN: begin
                     if (grp_inside) begin
                        srow_top_in = AW'(PANEL_ROWS - SCAN_GROUPS) + AW'(req_scan_group);
                        srow_in     = AW'(PANEL_ROWS - SCAN_GROUPS) + AW'(req_scan_group);
                        col_base_in = '0;
                        col_cnt_in  = '0;
                        row_cnt_in  = '0;
                        line_a_in   = LINE_A_CODE[req_scan_group];
                        line_b_in   = LINE_B_CODE[req_scan_group];
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     // unused code: taken and dropped
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_WRITE: begin
            // read data of the byte is back: set or clear the one bit
            ram_we      = 1'b1;
            ram_wr_addr = wr_addr_ff;
            ram_wr_data = wr_value_ff ? (ram_rd_data | bit_mask) : (ram_rd_data & ~bit_mask);
            state_in    = ST_IDLE;
         end

         ST_SCAN: begin
            ram_rd_addr = col_base_ff + srow_ff;
            if (scan_issue) begin
               inflight_in      = 1'b1;
               inflight_last_in = scan_row_last && scan_col_last;
               if (scan_row_last) begin
                  row_cnt_in  = '0;
                  srow_in     = srow_top_ff;
                  col_base_in = col_base_ff + AW'(PANEL_ROWS);
                  col_cnt_in  = col_cnt_ff + CW'(1);
                  if (scan_col_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  row_cnt_in = row_cnt_ff + RW'(1);
                  srow_in    = srow_ff - AW'(SCAN_GROUPS);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         inflight_ff <= inflight_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      wr_addr_ff       <= wr_addr_in;
      wr_bit_ff        <= wr_bit_in;
      wr_value_ff      <= wr_value_in;
      col_base_ff      <= col_base_in;
      srow_ff          <= srow_in;
      srow_top_ff      <= srow_top_in;
      col_cnt_ff       <= col_cnt_in;
      row_cnt_ff       <= row_cnt_in;
      line_a_ff        <= line_a_in;
      line_b_ff        <= line_b_in;
      inflight_a_ff    <= inflight_a_in;
      inflight_b_ff    <= inflight_b_in;
      inflight_last_ff <= inflight_last_in;
   end

   lpqsd_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (STORE_BYTES)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // panel drives active low, so the byte goes out inverted
   always_comb begin
      push_entry.shift_byte   = ~ram_rd_data;
      push_entry.row_select_a = inflight_a_ff;
      push_entry.row_select_b = inflight_b_ff;
      push_entry.latch_last   = inflight_last_ff;
   end

   lpqsd_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (inflight_ff),
      .push_entry (push_entry),
      .pop        (rsp_pop),
      .out_valid  (q_valid),
      .out_entry  (head_entry),
      .count      (q_count)
   );

   assign rsp_valid        = q_valid;
   assign rsp_shift_byte   = head_entry.shift_byte;
   assign rsp_row_select_a = head_entry.row_select_a;
   assign rsp_row_select_b = head_entry.row_select_b;
   assign rsp_latch_last   = head_entry.latch_last;

   // queue plus the read in flight never exceeds the two slots
   `LPQSD_ASSERT_NOW(a_credit_bound, clock, reset, inflight_ff, q_count != 2'd2)
   // a store write never shares a cycle with a scan read
   `LPQSD_ASSERT_NOW(a_port_exclusive, clock, reset, ram_we, !scan_issue)
   // the read carrying the latch flag ends the scan
   `LPQSD_ASSERT_NEXT(a_scan_ends, clock, reset, scan_issue && inflight_last_in,
                      state_ff == ST_IDLE)

endmodule

[src/lpqsd_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lpqsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lpqsd_out_queue.sv]
// two-entry result queue between the frame store read and the result channel
// depends on lpqsd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "led_panel_quarter_scan_driver_core_macros.svh"

module lpqsd_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lpqsd_pkg::out_entry_type push_entry,
   input  logic                    pop,
   output logic                    out_valid,
   output lpqsd_pkg::out_entry_type out_entry,
   output logic [1:0]              count
);

   import lpqsd_pkg::*;

   out_entry_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_entry = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   `LPQSD_ASSERT_NOW(a_no_overflow, clock, reset, push && (count_ff == 2'd2), pop)
   `LPQSD_ASSERT_NOW(a_no_underflow, clock, reset, pop, count_ff != 2'd0)
   `LPQSD_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)

endmodule
